/* src/wsdq_pkg.sv */
// Shared types and constants of the wavelet slice dequantiser.
// Depends on nothing; every module of the block imports it.
package wsdq_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_DIM_W   = 7;
  localparam int DEPTH_W     = 3;
  localparam int STRIDE_W    = 13;
  localparam int SUBBAND_W   = 4;
  localparam int FACTOR_W    = 31;
  localparam int COEF_W      = 32;
  localparam int SAMPLE_W    = 32;
  localparam int POS_W       = 7;
  localparam int COL_W       = 6;
  localparam int ADDR_W      = 18;
  localparam int ROWPROD_W   = POS_W + STRIDE_W;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 64;
  localparam int Q_DEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW     = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_COEF  = 1'b1;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] num_cols;
    logic [CFG_DIM_W-1:0] num_rows;
    logic [DEPTH_W-1:0]   transform_depth;
    logic [STRIDE_W-1:0]  row_stride;
    logic                 narrow_samples;
  } cfg_t;

  typedef struct packed {
    logic [COEF_W-1:0]   coef;
    logic [FACTOR_W-1:0] factor;
    logic [FACTOR_W-1:0] offset;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic                last;
  } fe_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [COL_W-1:0]    column;
    logic [COL_W-1:0]    row;
    logic [ADDR_W-1:0]   address;
    logic                last;
  } out_item_t;

endpackage

/* src/wsdq_front.sv */
// Front end: accepts beats, loads the quantiser tables, tracks the slice position.
// Depends on wsdq_pkg; feeds wsdq_queue.
module wsdq_front import wsdq_pkg::*; #(
  parameter int MAX_SLICE_DIM = 64,
  parameter int MAX_DEPTH     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 restart,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [SUBBAND_W-1:0] in_subband,
  input  logic [FACTOR_W-1:0]  in_factor,
  input  logic [FACTOR_W-1:0]  in_offset,
  input  logic [COEF_W-1:0]    in_coef,
  input  logic                 q_full,
  output logic                 q_push,
  output fe_item_t             q_item
);

  localparam int TABLE_SIZE = 3 * MAX_DEPTH + 1;
  localparam int TB_W       = $clog2(TABLE_SIZE);
  localparam int SB_EXT     = (SUBBAND_W > TB_W) ? SUBBAND_W : TB_W + 1;
  localparam int DIM_W      = $clog2(MAX_SLICE_DIM + 1);
  localparam int A_W        = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int CMP_W      = ((A_W > MAX_DEPTH + 1) ? A_W : MAX_DEPTH + 1) + 1;

  logic [FACTOR_W-1:0] factor_tab [TABLE_SIZE];
  logic [FACTOR_W-1:0] offset_tab [TABLE_SIZE];

  logic [TB_W-1:0]  band_r, band_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0]   w_eff, h_eff;
  logic [DEPTH_W-1:0] d_eff;
  logic [CMP_W-1:0]   step_a [TABLE_SIZE];
  logic [CMP_W-1:0]   x0_a [TABLE_SIZE];
  logic [CMP_W-1:0]   y0_a [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] nonempty;

  logic [CMP_W-1:0] col_sum, row_sum;
  logic             last;
  logic             accept;
  logic [SB_EXT-1:0] sb_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_op == OP_COEF);
  assign sb_ext   = SB_EXT'(in_subband);

  always_comb begin
    w_eff = CMP_W'(cfg.num_cols);
    if (w_eff == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_eff > CMP_W'(MAX_SLICE_DIM)) begin
      w_eff = CMP_W'(MAX_SLICE_DIM);
    end
    h_eff = CMP_W'(cfg.num_rows);
    if (h_eff == '0) begin
      h_eff = CMP_W'(1);
    end else if (h_eff > CMP_W'(MAX_SLICE_DIM)) begin
      h_eff = CMP_W'(MAX_SLICE_DIM);
    end
    d_eff = (cfg.transform_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                         : cfg.transform_depth;
  end

  for (genvar j = 0; j < TABLE_SIZE; j++) begin : g_band
    localparam int LV = (j == 0) ? 0 : ((j - 1) / 3 + 1);
    localparam int OR = (j == 0) ? 0 : ((j - 1) % 3 + 1);
    logic [CMP_W-1:0] half;
    always_comb begin
      if (j == 0) begin
        step_a[j] = CMP_W'(1) << d_eff;
        half      = '0;
        x0_a[j]   = '0;
        y0_a[j]   = '0;
        nonempty[j] = 1'b0;
      end else begin
        step_a[j] = CMP_W'(1) << (d_eff + DEPTH_W'(1) - DEPTH_W'(LV));
        half      = step_a[j] >> 1;
        x0_a[j]   = ((OR % 2) == 1) ? half : '0;
        y0_a[j]   = (OR >= 2) ? half : '0;
        nonempty[j] = (DEPTH_W'(LV) <= d_eff) && (x0_a[j] < w_eff) && (y0_a[j] < h_eff);
      end
    end
  end

  always_comb begin
    logic            found;
    logic [TB_W-1:0] next_band;
    found     = 1'b0;
    next_band = '0;
    for (int j = TABLE_SIZE - 1; j >= 0; j--) begin
      if (nonempty[j] && (TB_W'(j) > band_r)) begin
        found     = 1'b1;
        next_band = TB_W'(j);
      end
    end
    col_sum  = CMP_W'(col_r) + step_a[band_r];
    row_sum  = CMP_W'(row_r) + step_a[band_r];
    band_nxt = band_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    last     = 1'b0;
    if (col_sum < w_eff) begin
      col_nxt = POS_W'(col_sum);
    end else if (row_sum < h_eff) begin
      col_nxt = POS_W'(x0_a[band_r]);
      row_nxt = POS_W'(row_sum);
    end else if (found) begin
      band_nxt = next_band;
      col_nxt  = POS_W'(x0_a[next_band]);
      row_nxt  = POS_W'(y0_a[next_band]);
    end else begin
      band_nxt = '0;
      col_nxt  = '0;
      row_nxt  = '0;
      last     = 1'b1;
    end
  end

  always_comb begin
    q_item.coef   = in_coef;
    q_item.factor = factor_tab[band_r];
    q_item.offset = offset_tab[band_r];
    q_item.col    = col_r;
    q_item.row    = row_r;
    q_item.last   = last;
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_LOAD) && (sb_ext < SB_EXT'(TABLE_SIZE))) begin
      factor_tab[sb_ext[TB_W-1:0]] <= in_factor;
      offset_tab[sb_ext[TB_W-1:0]] <= in_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      band_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else if (q_push) begin
      band_r <= band_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

/* src/wsdq_queue.sv */
// Short queue between the front end and the arithmetic back end.
// Depends on wsdq_pkg for the entry type and depth.
module wsdq_queue import wsdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fe_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output fe_item_t pop_item
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  fe_item_t         mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* src/wsdq_back.sv */
// Back end: multiply, offset, shift and sign restore, buffer address, output register.
// Depends on wsdq_pkg; drains wsdq_queue.
module wsdq_back import wsdq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  fe_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic                 advance;
  logic [COEF_W-1:0]    mag;
  logic [COEF_W-1:0]    prod;

  logic                 s1_valid_r;
  logic [COEF_W-1:0]    s1_prod_r;
  logic [FACTOR_W-1:0]  s1_offset_r;
  logic                 s1_neg_r;
  logic                 s1_zero_r;
  logic [POS_W-1:0]     s1_col_r;
  logic [POS_W-1:0]     s1_row_r;
  logic                 s1_last_r;
  logic [ROWPROD_W-1:0] s1_rowprod_r;

  logic                 out_valid_r;
  out_item_t            out_item_r, out_item_nxt;

  logic [SAMPLE_W-1:0]  sum, shr, val;

  assign advance   = !out_valid_r || out_ready;
  assign q_pop     = q_valid && advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign mag  = q_item.coef[COEF_W-1] ? (~q_item.coef + COEF_W'(1)) : q_item.coef;
  assign prod = mag * {1'b0, q_item.factor};

  always_comb begin
    sum = s1_prod_r + {1'b0, s1_offset_r};
    shr = {{2{sum[SAMPLE_W-1]}}, sum[SAMPLE_W-1:2]};
    if (s1_zero_r) begin
      val = '0;
    end else if (s1_neg_r) begin
      val = ~shr + SAMPLE_W'(1);
    end else begin
      val = shr;
    end
    if (cfg.narrow_samples) begin
      val = {{16{val[15]}}, val[15:0]};
    end
    out_item_nxt.sample  = val;
    out_item_nxt.column  = s1_col_r[COL_W-1:0];
    out_item_nxt.row     = s1_row_r[COL_W-1:0];
    out_item_nxt.address = ADDR_W'(s1_rowprod_r + ROWPROD_W'(s1_col_r));
    out_item_nxt.last    = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod_r    <= prod;
      s1_offset_r  <= q_item.offset;
      s1_neg_r     <= q_item.coef[COEF_W-1];
      s1_zero_r    <= (q_item.coef == '0);
      s1_col_r     <= q_item.col;
      s1_row_r     <= q_item.row;
      s1_last_r    <= q_item.last;
      s1_rowprod_r <= ROWPROD_W'(q_item.row) * ROWPROD_W'(cfg.row_stride);
      out_item_r   <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_valid;
      out_valid_r <= s1_valid_r;
    end
  end

endmodule

/* src/wavelet_slice_dequantiser_core.sv */
// Top level of the wavelet slice dequantiser: configuration registers and the
// front end, queue and back end. Depends on wsdq_pkg, wsdq_front, wsdq_queue, wsdq_back.
//
// Usage:
//   in_*   : stream of beats. in_tuser = 0 loads the factor and offset of one
//            subband; in_tuser = 1 carries one coefficient of the slice, in
//            subband order. Load beats give no output.
//   out_*  : one beat per coefficient with the dequantised sample, its column,
//            row and buffer address; out_tlast marks the slice's final one.
//   cfg_*  : register writes, to be made only while the block is idle, though the block
//            does not enforce it; a write to a listed register restarts the slice position.
// An accepted coefficient passes the queue, the back-end stage register and the
// output register. Throughput is one beat per cycle while out_tready is high, set by
// the position update in the front end and the one-stage multiplier in the back end.
// Reset clears the position to the DC band at (0,0) and the registers to
// width 8, height 8, depth 2, stride 64, wide samples; the subband tables hold
// nothing until loaded. When out_tready is low the output beat holds, the
// back end stops, the two-entry queue fills and then in_tready falls.
module wavelet_slice_dequantiser_core import wsdq_pkg::*; #(
  parameter int MAX_SLICE_DIM = 64,
  parameter int MAX_DEPTH     = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // subband[3:0], quant_factor[34:4], quant_offset[65:35], coefficient[97:66]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // sample[31:0], column[37:32], row[43:38], address[61:44]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r;
  logic      restart;
  logic      q_push, q_full, q_pop, q_valid;
  fe_item_t  q_in_item, q_out_item;
  out_item_t out_item;

  always_comb begin
    case (cfg_index)
      REG_NUM_COLS, REG_NUM_ROWS, REG_DEPTH, REG_ROW_STRIDE, REG_NARROW:
        restart = cfg_wr_en;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_cols        <= CFG_DIM_W'(8);
      cfg_r.num_rows        <= CFG_DIM_W'(8);
      cfg_r.transform_depth <= DEPTH_W'(2);
      cfg_r.row_stride      <= STRIDE_W'(64);
      cfg_r.narrow_samples  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_COLS:   cfg_r.num_cols        <= cfg_wdata[CFG_DIM_W-1:0];
        REG_NUM_ROWS:   cfg_r.num_rows        <= cfg_wdata[CFG_DIM_W-1:0];
        REG_DEPTH:      cfg_r.transform_depth <= cfg_wdata[DEPTH_W-1:0];
        REG_ROW_STRIDE: cfg_r.row_stride      <= cfg_wdata[STRIDE_W-1:0];
        REG_NARROW:     cfg_r.narrow_samples  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  wsdq_front #(
    .MAX_SLICE_DIM(MAX_SLICE_DIM),
    .MAX_DEPTH    (MAX_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .restart    (restart),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_subband (in_tdata[3:0]),
    .in_factor  (in_tdata[34:4]),
    .in_offset  (in_tdata[65:35]),
    .in_coef    (in_tdata[97:66]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  wsdq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out_item)
  );

  wsdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_out_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {2'b00, out_item.address, out_item.row, out_item.column, out_item.sample};
  assign out_tlast = out_item.last;

endmodule

/* dv/wavelet_slice_dequantiser_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for wavelet_slice_dequantiser_core: clocked driver and monitor on
// the beat streams, checked against a predictor of samples and slice positions.
// Depends on wsdq_pkg and the core RTL.
module wavelet_slice_dequantiser_core_tb;
  import wsdq_pkg::*;

  localparam int MAX_DIM      = 64;
  localparam int MAX_LVL      = 4;
  localparam int LUT_DEPTH    = 3 * MAX_LVL + 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES       = 14;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                 op;
    logic [SUBBAND_W-1:0] subband;
    logic [FACTOR_W-1:0]  factor;
    logic [FACTOR_W-1:0]  offset;
    logic [COEF_W-1:0]    coef;
  } coef_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  wavelet_slice_dequantiser_core u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  // predictor state
  logic [31:0] factor_lut [LUT_DEPTH];
  logic [31:0] offset_lut [LUT_DEPTH];
  int lvl = 0, orient = 0, pos_col = 0, pos_row = 0;
  int cfg_width = 8, cfg_height = 8, cfg_depth = 2, cfg_stride = 64;
  bit cfg_narrow = 1'b0;

  coef_beat_t pending [$];
  out_item_t  expected_samples [$];

  int mismatches = 0, unexpected = 0, samples_checked = 0, slice_ends = 0;
  int loads_taken = 0, cycles = 0;
  bit calm = 1'b0, stall_req = 1'b0, hold_done = 1'b0;
  int hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_dim(int v);
    return v == 0 ? 1 : (v > MAX_DIM ? MAX_DIM : v);
  endfunction

  function automatic int eff_depth();
    return cfg_depth > MAX_LVL ? MAX_LVL : cfg_depth;
  endfunction

  function automatic void band_geometry(input int l, input int o,
                                        output int s, output int x0, output int y0);
    int d;
    d = eff_depth();
    if (l == 0 || l > d) begin
      s = 1 << d;
      x0 = 0;
      y0 = 0;
    end else begin
      s = 1 << (d - l + 1);
      x0 = (o & 1) ? s / 2 : 0;
      y0 = (o & 2) ? s / 2 : 0;
    end
  endfunction

  // step to the next in-place position; returns 1 when the slice wraps
  function automatic bit advance_position();
    int w, h, d, s, x0, y0;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    d = eff_depth();
    band_geometry(lvl, orient, s, x0, y0);
    if (pos_col + s < w) begin
      pos_col += s;
      return 1'b0;
    end
    if (pos_row + s < h) begin
      pos_col = x0;
      pos_row += s;
      return 1'b0;
    end
    while (1) begin
      if (lvl == 0) begin
        lvl = 1;
        orient = 1;
      end else if (orient < 3) begin
        orient++;
      end else begin
        lvl++;
        orient = 1;
      end
      if (lvl > d) begin
        lvl = 0;
        orient = 0;
        pos_col = 0;
        pos_row = 0;
        return 1'b1;
      end
      band_geometry(lvl, orient, s, x0, y0);
      if (x0 < w && y0 < h) begin
        pos_col = x0;
        pos_row = y0;
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_NUM_COLS:   cfg_width = int'(val[CFG_DIM_W-1:0]);
      REG_NUM_ROWS:   cfg_height = int'(val[CFG_DIM_W-1:0]);
      REG_DEPTH:      cfg_depth = int'(val[DEPTH_W-1:0]);
      REG_ROW_STRIDE: cfg_stride = int'(val[STRIDE_W-1:0]);
      REG_NARROW:     cfg_narrow = val[0];
      default:        return;
    endcase
    lvl = 0;
    orient = 0;
    pos_col = 0;
    pos_row = 0;
  endfunction

  function automatic void predict_dequant(coef_beat_t b);
    logic [31:0] mag, v;
    int sb, addr;
    out_item_t r;
    if (b.op == OP_LOAD) begin
      loads_taken++;
      if (b.subband < LUT_DEPTH) begin
        factor_lut[b.subband] = {1'b0, b.factor};
        offset_lut[b.subband] = {1'b0, b.offset};
      end
      return;
    end
    sb = (lvl == 0) ? 0 : 3 * (lvl - 1) + orient;
    if (sb >= LUT_DEPTH) sb = 0;
    mag = b.coef[31] ? -b.coef : b.coef;
    v = mag * factor_lut[sb] + offset_lut[sb];
    v = $signed(v) >>> 2;
    if (b.coef == '0) v = '0;
    else if (b.coef[31]) v = -v;
    if (cfg_narrow) v = {{16{v[15]}}, v[15:0]};
    addr = pos_row * cfg_stride + pos_col;
    r.sample = v;
    r.column = pos_col[COL_W-1:0];
    r.row = pos_row[COL_W-1:0];
    r.address = addr[ADDR_W-1:0];
    r.last = advance_position();
    expected_samples.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : drive
    coef_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= IN_TDATA_W'({nxt.coef, nxt.offset, nxt.factor, nxt.subband});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin : watch
    out_item_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_dequant({in_tuser, in_tdata[3:0], in_tdata[34:4], in_tdata[65:35],
                         in_tdata[97:66]});
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata[31:0];
        got.column = out_tdata[37:32];
        got.row = out_tdata[43:38];
        got.address = out_tdata[61:44];
        got.last = out_tlast;
        if (expected_samples.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected beat: s=%h c=%0d r=%0d a=%h l=%b",
                     got.sample, got.column, got.row, got.address, got.last);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (want.last) slice_ends++;
          if (got.sample !== want.sample || got.column !== want.column ||
              got.row !== want.row || got.address !== want.address ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch: exp s=%h c=%0d r=%0d a=%h l=%b, got s=%h c=%0d r=%0d a=%h l=%b",
                       want.sample, want.column, want.row, want.address, want.last,
                       got.sample, got.column, got.row, got.address, got.last);
          end
        end
      end
    end
  end

  task automatic settle();
    while (pending.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    set_register(idx, val);
    @(posedge clk);
  endtask

  initial begin : stimulus
    coef_beat_t b;
    int n, w, h, d, stride;
    bit nar;
    int fix_w [5] = '{64, 1, 0, 127, 3};
    int fix_h [5] = '{1, 64, 127, 0, 5};
    int fix_d [5] = '{4, 3, 7, 0, 1};
    int fix_s [5] = '{4096, 8191, 0, 1, 8191};
    bit fix_n [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [31:0] corner_coefs [8] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
                                      32'h80000000, 32'd1000, -32'sd1000, 32'h12345678};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // load every table entry first, with the field extremes on the DC entry
    for (int i = 0; i < LUT_DEPTH; i++) begin
      b = '0;
      b.op = OP_LOAD;
      b.subband = SUBBAND_W'(i);
      b.factor = (i == 0) ? 31'h7FFFFFFF : FACTOR_W'(3 * i + 1);
      b.offset = (i == 0) ? 31'h7FFFFFFF : FACTOR_W'(i);
      pending.push_back(b);
    end
    b = '0;
    b.op = OP_LOAD;
    b.subband = 4'hF;
    b.factor = 31'h5A5A5A5A;
    b.offset = 31'h2A2A2A2A;
    pending.push_back(b);
    foreach (corner_coefs[i]) begin
      b = '0;
      b.op = OP_COEF;
      b.coef = corner_coefs[i];
      pending.push_back(b);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 5) begin
        w = fix_w[p];
        h = fix_h[p];
        d = fix_d[p];
        stride = fix_s[p];
        nar = fix_n[p];
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
        case ($urandom_range(4))
          0: begin
            w = $urandom_range(0, 127);
            h = $urandom_range(0, 3);
          end
          1: begin
            h = $urandom_range(0, 127);
            w = $urandom_range(0, 3);
          end
          default: ;
        endcase
        d = $urandom_range(0, 7);
        stride = ($urandom_range(3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 80);
        nar = 1'($urandom_range(1));
      end
      @(posedge clk);
      if (p == 7) write_reg(REG_UNUSED, 13'h1FFF);
      write_reg(REG_NUM_COLS, CFG_DATA_W'(w));
      write_reg(REG_NUM_ROWS, CFG_DATA_W'(h));
      write_reg(REG_DEPTH, CFG_DATA_W'(d));
      write_reg(REG_ROW_STRIDE, CFG_DATA_W'(stride));
      write_reg(REG_NARROW, CFG_DATA_W'(nar));
      cfg_wr_en <= 1'b0;
      calm = (p == 3);

      n = $urandom_range(70, 130);
      repeat (n) begin
        b.subband = SUBBAND_W'($urandom);
        b.factor = FACTOR_W'($urandom);
        b.offset = FACTOR_W'($urandom);
        b.coef = $urandom;
        if ($urandom_range(99) < 8) begin
          b.op = OP_LOAD;
          b.subband = SUBBAND_W'($urandom_range(15));
          b.factor = FACTOR_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 64));
          b.offset = FACTOR_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 8));
        end else begin
          b.op = OP_COEF;
          case ($urandom_range(9))
            0, 1, 2, 3, 4: b.coef = $urandom_range(0, 4000) - 2000;
            5, 6, 7:       b.coef = $urandom;
            8:             b.coef = corner_coefs[$urandom_range(7)];
            default:       b.coef = '0;
          endcase
        end
        pending.push_back(b);
      end
      if (p == 8) stall_req = 1'b1;
    end

    settle();
    $display("covered %0d dequantised samples, %0d slice ends, %0d table loads",
             samples_checked, slice_ends, loads_taken);
    $display("over %0d register settings incl. clamped sizes, depth and zero stride",
             PHASES + 1);
    if (mismatches == 0 && unexpected == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
